>>> hdl/ttps_pkg.sv
// Shared types and status codes for the Tarry token port-select node.
`timescale 1ns / 1ps

package ttps_pkg;

	// Result status codes.
	localparam logic [1:0] STAT_CHILD   = 2'd0;
	localparam logic [1:0] STAT_FATHER  = 2'd1;
	localparam logic [1:0] STAT_DECIDED = 2'd2;
	localparam logic [1:0] STAT_DONE    = 2'd3;

	// Input opcodes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_TOKEN = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_IS_INITIATOR = 1'b0;
	localparam logic CFG_PORT_COUNT   = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [2:0] arrival_port;
		logic [2:0] pick;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       send_valid;
		logic [2:0] out_port;
	} result_t;

endpackage

>>> hdl/ttps_seq.sv
// Sequencer that scans the ports, reduces the pick and selects the outgoing port.
`timescale 1ns / 1ps

module ttps_seq #(
	parameter int PORTS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  ttps_pkg::item_t                   item,
	input  logic                              is_initiator,
	input  logic [$clog2(PORTS + 1) - 1:0]    port_n,
	input  logic                              res_load,
	output logic                              idle,
	output logic                              res_valid,
	output ttps_pkg::result_t                 res
);
	import ttps_pkg::*;

	localparam int NW = $clog2(PORTS + 1);
	localparam int PW = $clog2(PORTS);
	localparam int CW = (NW > 3) ? NW : 3;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_COUNT  = 3'd1;
	localparam logic [2:0] ST_MOD    = 3'd2;
	localparam logic [2:0] ST_SELECT = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;

	logic [2:0]       state_q;
	logic [PORTS-1:0] used_q;
	logic             father_known_q;
	logic             father_is_self_q;
	logic [2:0]       father_port_q;
	logic [NW-1:0]    p_q;
	logic [NW-1:0]    cand_q;
	logic             any_q;
	logic [2:0]       k_q;
	logic [2:0]       seen_q;
	result_t          res_q;

	logic [PW-1:0] p_idx;
	logic [PW-1:0] fp_idx;
	logic          p_is_cand;
	logic          fp_in_range;
	logic          k_ge_cand;

	assign p_idx       = p_q[PW-1:0];
	assign fp_idx      = PW'(father_port_q);
	assign p_is_cand   = !used_q[p_idx] && (father_is_self_q || CW'(p_q) != CW'(father_port_q));
	assign fp_in_range = 32'(father_port_q) < PORTS;
	// The one compare-and-subtract unit that reduces the pick modulo the candidate count.
	assign k_ge_cand   = CW'(k_q) >= CW'(cand_q);

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			used_q           <= '0;
			father_known_q   <= 1'b0;
			father_is_self_q <= 1'b0;
			father_port_q    <= 3'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (is_initiator) begin
							father_known_q   <= 1'b1;
							father_is_self_q <= 1'b1;
							state_q          <= ST_COUNT;
						end else if (item.opcode == OP_TOKEN) begin
							if (!father_known_q) begin
								father_known_q   <= 1'b1;
								father_is_self_q <= 1'b0;
								father_port_q    <= item.arrival_port;
							end
							state_q <= ST_COUNT;
						end
					end
				end
				ST_COUNT: begin
					if (p_q == port_n) begin
						if (!any_q) begin
							state_q <= ST_FIN;
						end else if (cand_q == '0) begin
							if (fp_in_range) begin
								used_q[fp_idx] <= 1'b1;
							end
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (!k_ge_cand) begin
						state_q <= ST_SELECT;
					end
				end
				ST_SELECT: begin
					if (p_is_cand && seen_q == k_q) begin
						used_q[p_idx] <= 1'b1;
						state_q       <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the scan; they carry no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				p_q    <= '0;
				cand_q <= '0;
				any_q  <= 1'b0;
				k_q    <= item.pick;
			end
			ST_COUNT: begin
				if (p_q == port_n) begin
					p_q    <= '0;
					seen_q <= 3'd0;
					if (!any_q) begin
						res_q.status     <= is_initiator ? STAT_DECIDED : STAT_DONE;
						res_q.send_valid <= 1'b0;
						res_q.out_port   <= 3'd0;
					end else begin
						res_q.status     <= STAT_FATHER;
						res_q.send_valid <= 1'b1;
						res_q.out_port   <= father_port_q;
					end
				end else begin
					if (!used_q[p_idx]) begin
						any_q <= 1'b1;
					end
					if (p_is_cand) begin
						cand_q <= cand_q + 1'b1;
					end
					p_q <= p_q + 1'b1;
				end
			end
			ST_MOD: begin
				if (k_ge_cand) begin
					k_q <= 3'(CW'(k_q) - CW'(cand_q));
				end
			end
			ST_SELECT: begin
				if (p_is_cand) begin
					if (seen_q == k_q) begin
						res_q.status     <= STAT_CHILD;
						res_q.send_valid <= 1'b1;
						res_q.out_port   <= 3'(p_q);
					end else begin
						seen_q <= seen_q + 3'd1;
					end
				end
				p_q <= p_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hdl/tarry_token_port_select.sv
// Top level of one Tarry traversal node that picks its outgoing port by rank.
//
//  Channel   Direction  Signals                             Contents
//  s_*       in         s_tvalid s_tready s_tdata s_tuser   one event: start or token
//  m_*       out        m_tvalid m_tready m_tdata           one result per handled event
//  cfg_*     in         cfg_wr_en cfg_index cfg_data        is_initiator, port_count
//
// The time an event takes depends on the port scans and on the subtract loop that
// reduces the pick. Reset clears the port-used flags and the father state, and sets
// is_initiator to 0 and port_count to 8. The result waits in an output register; a new
// event is taken once the sequencer is idle, and the sequencer holds its last state
// while that register is still full. A start event at a non-initiator is dropped with
// no result.
`timescale 1ns / 1ps

module tarry_token_port_select #(
	parameter int PORTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // arrival_port[2:0], pick[5:3], zero[7:6]
	input  logic       s_tuser,   // opcode[0]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // status[1:0], send_valid[2], out_port[5:3], zero[7:6]
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data
);
	import ttps_pkg::*;

	localparam int NW = $clog2(PORTS + 1);

	logic          is_initiator_q;
	logic [3:0]    port_count_q;
	logic [NW-1:0] port_n;
	item_t         item;
	logic          seq_idle;
	logic          res_valid;
	result_t       res;
	logic          res_load;
	logic          m_valid_q;
	result_t       m_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_initiator_q <= 1'b0;
			port_count_q   <= 4'd8;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_IS_INITIATOR: is_initiator_q <= cfg_data[0];
				CFG_PORT_COUNT:   port_count_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign port_n = (32'(port_count_q) > PORTS) ? NW'(PORTS) : NW'(port_count_q);

	assign item.opcode       = s_tuser;
	assign item.arrival_port = s_tdata[2:0];
	assign item.pick         = s_tdata[5:3];

	assign s_tready = seq_idle;

	ttps_seq #(
		.PORTS(PORTS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (s_tvalid && seq_idle),
		.item        (item),
		.is_initiator(is_initiator_q),
		.port_n      (port_n),
		.res_load    (res_load),
		.idle        (seq_idle),
		.res_valid   (res_valid),
		.res         (res)
	);

	assign res_load = res_valid && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_res_q.out_port, m_res_q.send_valid, m_res_q.status};

endmodule
